FILE: src/gsr_pkg.sv
// shared types and constants for the grid relaxation block
package gsr_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_GRID_SIZE  = 3'd0,
    REG_SWEEPS     = 3'd1,
    REG_BND_MODE   = 3'd2,
    REG_COUPLING   = 3'd3,
    REG_INV_DIV    = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    BND_KEEP  = 2'd0,
    BND_COLS  = 2'd1,
    BND_ROWS  = 2'd2,
    BND_OTHER = 2'd3
  } bnd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RD1,
    ST_RD2,
    ST_SUM,
    ST_ML,
    ST_MH,
    ST_MF,
    ST_EDGE,
    ST_CORNER,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [5:0]  grid_size;
    logic [7:0]  sweep_count;
    logic [1:0]  boundary_mode;
    logic [30:0] coupling;
    logic [30:0] inverse_divisor;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic        in_grid;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] cell_value;
    logic [31:0] source_value;
  } qent_t;

  localparam int unsigned QDEPTH = 4;

endpackage

FILE: src/gsr_front.sv
// request intake, classification and queue toward the execution side
module gsr_front import gsr_pkg::*; #(
  parameter int unsigned MAX_INTERIOR = 62
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [31:0] cell_value_i,
  input  logic [31:0] source_value_i,
  output logic        q_valid_o,
  output qent_t       q_data_o,
  input  logic        q_pop_i
);

  localparam int unsigned STRIDE = MAX_INTERIOR + 2;
  localparam int unsigned PW = $clog2(QDEPTH);

  qent_t         fifo_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;
  qent_t         ent;

  always_comb begin
    ent.in_grid      = (32'(col_i) < STRIDE) && (32'(row_i) < STRIDE);
    ent.row          = row_i;
    ent.col          = col_i;
    ent.cell_value   = cell_value_i;
    ent.source_value = source_value_i;
    ent.cmd          = cmd_e'(cmd_i);
  end

  assign in_stall_o = (cnt_q == (PW+1)'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_data_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= ent;
    end
  end

endmodule

FILE: src/gsr_back.sv
// execution side: grid memories, sweep sequencer, shared multiplier and result register
module gsr_back import gsr_pkg::*; #(
  parameter int unsigned MAX_INTERIOR = 62
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  qent_t       q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_value_o,
  output logic        solve_done_o,
  output logic        saturated_o
);

  localparam int unsigned STRIDE = MAX_INTERIOR + 2;
  localparam int unsigned AW     = $clog2(STRIDE);
  localparam int unsigned DEPTH  = 1 << (2 * AW);

  logic [31:0] sol_mem [DEPTH];
  logic [31:0] src_mem [DEPTH];

  st_e state_q, state_d;

  logic [AW-1:0]   r_q, r_d, c_q, c_d, bk_q, bk_d;
  logic            side_q, side_d;
  logic [1:0]      corner_q, corner_d;
  logic [7:0]      sweep_q, sweep_d;
  logic            pass_q, pass_d;
  logic            in_grid_q, in_grid_d;
  logic            sat_q, sat_d;
  logic [48:0]     m_q, m_d;
  logic            neg_q, neg_d;
  logic [46:0]     lo_q;
  logic [63:0]     hi_q;
  logic [32:0]     part_q;
  logic [31:0]     rda_q, rdb_q, src_rd_q;
  logic            out_valid_q;
  logic [31:0]     rv_q, rv_d;
  logic            done_q, done_d, osat_q, osat_d;

  logic [AW-1:0]   n, np1;
  logic [2*AW-1:0] ra, rb, rs, wa;
  logic            sol_we, src_we, out_load, out_free, pop;
  logic [31:0]     wd;
  logic [30:0]     kmul;
  logic [33:0]     sum, sum_mag;
  logic [63:0]     q;
  logic [49:0]     t;
  logic [48:0]     t_mag;
  logic [AW-1:0]   er, ec;

  function automatic logic [2*AW-1:0] adr(input logic [AW-1:0] rr, input logic [AW-1:0] cc);
    return {rr, cc};
  endfunction

  always_comb begin
    if (cfg_i.grid_size == '0) begin
      n = AW'(1);
    end else if (32'(cfg_i.grid_size) > MAX_INTERIOR) begin
      n = AW'(MAX_INTERIOR);
    end else begin
      n = AW'(cfg_i.grid_size);
    end
    np1 = n + AW'(1);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign kmul     = pass_q ? cfg_i.inverse_divisor : cfg_i.coupling;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          case (q_data_i.cmd)
            CMD_READ:  state_d = ST_READ;
            CMD_SOLVE: state_d = (cfg_i.sweep_count == '0) ? ST_DONE : ST_RD1;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   if (out_free) state_d = ST_IDLE;
      ST_RD1:    state_d = ST_RD2;
      ST_RD2:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_ML;
      ST_ML:     state_d = ST_MH;
      ST_MH:     state_d = ST_MF;
      ST_MF: begin
        if (!pass_q) begin
          state_d = ST_ML;
        end else if (r_q == n && c_q == n) begin
          state_d = ST_EDGE;
        end else begin
          state_d = ST_RD1;
        end
      end
      ST_EDGE: begin
        if ((cfg_i.boundary_mode != BND_COLS && cfg_i.boundary_mode != BND_ROWS) ||
            (side_q && bk_q == n)) begin
          state_d = ST_CORNER;
        end
      end
      ST_CORNER: begin
        if (corner_q == 2'd3) begin
          state_d = (sweep_q + 8'd1 == cfg_i.sweep_count) ? ST_DONE : ST_RD1;
        end
      end
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    r_d = r_q; c_d = c_q; bk_d = bk_q; side_d = side_q; corner_d = corner_q;
    sweep_d = sweep_q; pass_d = pass_q; in_grid_d = in_grid_q; sat_d = sat_q;
    m_d = m_q; neg_d = neg_q;
    rv_d = rv_q; done_d = done_q; osat_d = osat_q;
    pop = 1'b0; out_load = 1'b0; sol_we = 1'b0; src_we = 1'b0;
    wa = adr(r_q, c_q); wd = '0;
    ra = adr(r_q, c_q); rb = adr(r_q, c_q); rs = adr(r_q, c_q);
    er = '0; ec = '0;
    sum = {part_q[32], part_q} + {{2{rda_q[31]}}, rda_q} + {{2{rdb_q[31]}}, rdb_q};
    sum_mag = sum[33] ? -sum : sum;
    q = hi_q + 64'(lo_q[46:16]) + 64'(neg_q && (lo_q[15:0] != '0));
    t = {{18{src_rd_q[31]}}, src_rd_q} +
        (neg_q ? -{2'b00, q[47:0]} : {2'b00, q[47:0]});
    if ($signed(t) > $signed(50'sd1 <<< 48)) begin
      t = 50'd1 << 48;
    end else if ($signed(t) < -$signed(50'sd1 <<< 48)) begin
      t = -(50'd1 << 48);
    end
    t_mag = t[49] ? 49'(-t) : t[48:0];

    case (state_q)
      ST_IDLE: begin
        ra = adr(AW'(q_data_i.row), AW'(q_data_i.col));
        if (q_valid_i && out_free) begin
          pop = 1'b1;
          r_d = AW'(q_data_i.row);
          c_d = AW'(q_data_i.col);
          in_grid_d = q_data_i.in_grid;
          case (q_data_i.cmd)
            CMD_WRITE: begin
              sol_we = q_data_i.in_grid;
              src_we = q_data_i.in_grid;
              wa = adr(AW'(q_data_i.row), AW'(q_data_i.col));
              wd = q_data_i.cell_value;
              out_load = 1'b1; rv_d = '0; done_d = 1'b0; osat_d = sat_q;
            end
            CMD_SOLVE: begin
              sat_d = 1'b0;
              r_d = AW'(1); c_d = AW'(1); sweep_d = '0;
            end
            CMD_READ: ;
            default: begin
              out_load = 1'b1; rv_d = '0; done_d = 1'b0; osat_d = sat_q;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          rv_d = in_grid_q ? rda_q : '0;
          done_d = 1'b0; osat_d = sat_q;
        end
      end
      ST_RD1: begin
        ra = adr(r_q, c_q - AW'(1));
        rb = adr(r_q, c_q + AW'(1));
      end
      ST_RD2: begin
        ra = adr(r_q - AW'(1), c_q);
        rb = adr(r_q + AW'(1), c_q);
      end
      ST_SUM: begin
        m_d = 49'(sum_mag); neg_d = sum[33]; pass_d = 1'b0;
      end
      ST_MF: begin
        if (!pass_q) begin
          m_d = t_mag; neg_d = t[49]; pass_d = 1'b1;
        end else begin
          sol_we = 1'b1;
          if (!neg_q) begin
            if (q > 64'h7FFF_FFFF) begin
              wd = 32'h7FFF_FFFF; sat_d = 1'b1;
            end else begin
              wd = q[31:0];
            end
          end else begin
            if (q > 64'h8000_0000) begin
              wd = 32'h8000_0000; sat_d = 1'b1;
            end else begin
              wd = -q[31:0];
            end
          end
          if (r_q == n) begin
            r_d = AW'(1);
            if (c_q == n) begin
              bk_d = AW'(1); side_d = 1'b0;
            end else begin
              c_d = c_q + AW'(1);
            end
          end else begin
            r_d = r_q + AW'(1);
          end
        end
      end
      ST_EDGE: begin
        corner_d = '0;
        if (cfg_i.boundary_mode == BND_COLS) begin
          er = bk_q; ec = side_q ? np1 : '0;
        end else begin
          er = side_q ? np1 : '0; ec = bk_q;
        end
        wa = adr(er, ec);
        sol_we = (cfg_i.boundary_mode == BND_COLS) || (cfg_i.boundary_mode == BND_ROWS);
        side_d = !side_q;
        if (side_q) bk_d = bk_q + AW'(1);
      end
      ST_CORNER: begin
        er = corner_q[1] ? np1 : '0;
        ec = corner_q[0] ? np1 : '0;
        wa = adr(er, ec);
        sol_we = 1'b1;
        corner_d = corner_q + 2'd1;
        if (corner_q == 2'd3) begin
          sweep_d = sweep_q + 8'd1;
          r_d = AW'(1); c_d = AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1; rv_d = '0; done_d = 1'b1; osat_d = sat_q;
        end
      end
      default: ;
    endcase
  end

  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
      sweep_q     <= '0;
      side_q      <= 1'b0;
      corner_q    <= '0;
    end else begin
      state_q     <= state_d;
      sat_q       <= sat_d;
      pass_q      <= pass_d;
      sweep_q     <= sweep_d;
      side_q      <= side_d;
      corner_q    <= corner_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    c_q       <= c_d;
    bk_q      <= bk_d;
    in_grid_q <= in_grid_d;
    m_q       <= m_d;
    neg_q     <= neg_d;
    rv_q      <= rv_d;
    done_q    <= done_d;
    osat_q    <= osat_d;
    lo_q      <= m_q[15:0] * kmul;
    hi_q      <= m_q[48:16] * kmul;
    if (state_q == ST_RD2) begin
      part_q <= {rda_q[31], rda_q} + {rdb_q[31], rdb_q};
    end
    rda_q    <= sol_mem[ra];
    rdb_q    <= sol_mem[rb];
    src_rd_q <= src_mem[rs];
    if (sol_we) sol_mem[wa] <= wd;
    if (src_we) src_mem[wa] <= q_data_i.source_value;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign solve_done_o = done_q;
  assign saturated_o  = osat_q;

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_IDLE) else $error("queue pop outside idle");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result overwritten");
  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD1 |-> (r_q >= AW'(1) && r_q <= n && c_q >= AW'(1) && c_q <= n))
    else $error("cell index out of range");
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD1 |-> sweep_q < cfg_i.sweep_count) else $error("sweep overrun");
  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> (state_q == ST_DONE || state_q == ST_IDLE))
    else $error("bad exit from done");
`endif

endmodule

FILE: src/gauss_seidel_grid_relaxation.sv
// top level of the gauss-seidel grid relaxation block
// usage:
//  configuration registers (grid size, sweeps, boundary mode, coupling,
//  inverse divisor) are written through cfg_we_i/cfg_index_i/cfg_data_i
//  while the block is idle; writes take effect at once
//  requests enter on in_valid_i/in_stall_o: write cell, solve, read cell
//  every request returns exactly one result on out_valid_o/out_stall_i
//  a four-entry queue takes requests while the execution side is busy
//  cell write: taken from idle; the memory write and result load coincide
//  cell read: registered memory read, then result register
//  solve: each sweep relaxes every interior cell, then zeroes the
//  border in column or row mode, and always the corners; the
//  shared multiplier is used twice per cell (coupling, inverse divisor)
//  reset clears the queue, result valid and saturation flag; grid
//  memories are not cleared and hold nothing until written
//  a stalled result holds; the execution side waits on it and the queue
//  fills, then in_stall_o rises
module gauss_seidel_grid_relaxation import gsr_pkg::*; #(
  parameter int unsigned MAX_INTERIOR = 62
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [31:0] cell_value_i,
  input  logic [31:0] source_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_value_o,
  output logic        solve_done_o,
  output logic        saturated_o
);

  cfg_t  cfg_q;
  logic  q_valid, q_pop;
  qent_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_size       <= 6'd62;
      cfg_q.sweep_count     <= 8'd20;
      cfg_q.boundary_mode   <= BND_KEEP;
      cfg_q.coupling        <= 31'd65536;
      cfg_q.inverse_divisor <= 31'd16384;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_SIZE: cfg_q.grid_size       <= cfg_data_i[5:0];
        REG_SWEEPS:    cfg_q.sweep_count     <= cfg_data_i[7:0];
        REG_BND_MODE:  cfg_q.boundary_mode   <= cfg_data_i[1:0];
        REG_COUPLING:  cfg_q.coupling        <= cfg_data_i;
        REG_INV_DIV:   cfg_q.inverse_divisor <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gsr_front #(.MAX_INTERIOR(MAX_INTERIOR)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .col_i, .row_i,
    .cell_value_i, .source_value_i,
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  gsr_back #(.MAX_INTERIOR(MAX_INTERIOR)) u_back (
    .clk_i, .rst_ni,
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .read_value_o, .solve_done_o, .saturated_o
  );

endmodule
